/* rtl/qte_pkg.sv */
// Shared constants, types and helpers for the quaternion to Euler angle pipeline.
// No dependencies.
`default_nettype none
package qte_pkg;
   localparam int QW  = 16;  // quaternion component width
   localparam int AW  = 16;  // output angle width
   localparam int NST = 16;  // CORDIC stages
   localparam int SW  = 35;  // exact Q2.30 sums with headroom
   localparam int CW  = 40;  // CORDIC datapath width
   localparam int RW  = 31;  // square root result width
   localparam int NW  = 62;  // square root radicand / remainder width
   localparam int PW  = 2 * QW;

   localparam logic [31:0] ATAN_TURNS [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   localparam logic [31:0] HALF_TURN = 32'h80000000;
   localparam logic signed [AW-1:0] QUARTER_POS = AW'(1) <<< (AW - 2);
   localparam logic signed [AW-1:0] QUARTER_NEG = -QUARTER_POS;

   typedef logic signed [SW-1:0] sum_type;

   typedef struct packed {
      sum_type sr;
      sum_type cr;
      sum_type sy;
      sum_type cy;
      sum_type sp;
      logic    clamped;
   } side_type;

   function automatic logic [AW-1:0] to_angle(input logic [31:0] t);
      logic [31:0] r;
      r = t + (32'd1 << (31 - AW));
      return r[31 -: AW];
   endfunction
endpackage
`default_nettype wire

/* rtl/qte_isqrt.sv */
// Pipelined floor square root, one result bit per stage, with a sideband payload.
// Depends on qte_pkg.
`default_nettype none
module qte_isqrt import qte_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           en,
   input  wire logic           in_valid,
   input  wire logic [NW-1:0]  in_n,
   input  wire side_type       in_side,
   output logic                out_valid,
   output logic [RW-1:0]       out_root,
   output side_type            out_side
);
   logic [NW-1:0] rem_ff   [0:RW];
   logic [RW-1:0] root_ff  [0:RW];
   side_type      side_ff  [0:RW];
   logic          valid_ff [0:RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         rem_ff[0]   <= in_n;
         root_ff[0]  <= '0;
         side_ff[0]  <= in_side;
      end
   end

   for (genvar j = 1; j <= RW; j++) begin : g_stage
      localparam int K = RW - j;
      logic [NW-1:0] trial;
      assign trial = ({{(NW-RW){1'b0}}, root_ff[j-1]} << (K + 1)) + (NW'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
            side_ff[j]  <= side_ff[j-1];
            if (rem_ff[j-1] >= trial) begin
               rem_ff[j]  <= rem_ff[j-1] - trial;
               root_ff[j] <= root_ff[j-1] | (RW'(1) << K);
            end else begin
               rem_ff[j]  <= rem_ff[j-1];
               root_ff[j] <= root_ff[j-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];
endmodule
`default_nettype wire

/* rtl/qte_cordic.sv */
// Pipelined vectoring CORDIC computing atan2(y, x) in 32-bit turn units.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic import qte_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] in_y,
   input  wire logic signed [CW-1:0] in_x,
   output logic                      out_valid,
   output logic [31:0]               out_angle
);
   logic signed [CW-1:0] x_ff     [0:NST];
   logic signed [CW-1:0] y_ff     [0:NST];
   logic [31:0]          ang_ff   [0:NST];
   logic                 zero_ff  [0:NST];
   logic                 valid_ff [0:NST];

   // fold the left half plane onto the right
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         zero_ff[0]  <= (in_x == '0) && (in_y == '0);
         if (in_x < 0) begin
            x_ff[0]   <= -in_x;
            y_ff[0]   <= -in_y;
            ang_ff[0] <= HALF_TURN;
         end else begin
            x_ff[0]   <= in_x;
            y_ff[0]   <= in_y;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar j = 1; j <= NST; j++) begin : g_stage
      localparam int I = j - 1;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      assign xs = x_ff[j-1] >>> I;
      assign ys = y_ff[j-1] >>> I;
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_ff[j-1];
            zero_ff[j]  <= zero_ff[j-1];
            if (y_ff[j-1] >= 0) begin
               x_ff[j]   <= x_ff[j-1] + ys;
               y_ff[j]   <= y_ff[j-1] - xs;
               ang_ff[j] <= ang_ff[j-1] + ATAN_TURNS[I];
            end else begin
               x_ff[j]   <= x_ff[j-1] - ys;
               y_ff[j]   <= y_ff[j-1] + xs;
               ang_ff[j] <= ang_ff[j-1] - ATAN_TURNS[I];
            end
         end
      end
   end

   assign out_valid = valid_ff[NST];
   assign out_angle = zero_ff[NST] ? 32'd0 : ang_ff[NST];
endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_angles.sv */
// Top level: quaternion (Q1.15) to roll, pitch, yaw binary angles, ZYX order.
// Depends on qte_pkg, qte_isqrt, qte_cordic.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_quat_x/y/z/w     | in
//   rsp     | rsp_valid rsp_stall rsp_roll/pitch/yaw_angle rsp_pitch_clamped | out
//
// One word enters per cycle while req_stall is low; the path is products, sums, square,
// a bit-per-stage square root, then 17 CORDIC stages and the output register.
// Synchronous reset clears all valid bits; no other state.
// A two-entry output register and skid absorb one word while rsp_stall is high;
// the pipeline then halts, and req_stall rises once the skid entry is occupied.
`default_nettype none
module quaternion_to_euler_angles import qte_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [QW-1:0] req_quat_x,
   input  wire logic signed [QW-1:0] req_quat_y,
   input  wire logic signed [QW-1:0] req_quat_z,
   input  wire logic signed [QW-1:0] req_quat_w,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [AW-1:0]      rsp_roll_angle,
   output logic signed [AW-1:0]      rsp_pitch_angle,
   output logic signed [AW-1:0]      rsp_yaw_angle,
   output logic                      rsp_pitch_clamped
);
   localparam logic signed [SW-1:0] ONE = SW'(1) <<< 30;

   logic en;
   logic take;

   // stage 1: products
   logic                 v1_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         wy_ff <= req_quat_w * req_quat_y;
         zx_ff <= req_quat_z * req_quat_x;
         wz_ff <= req_quat_w * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
      end
   end

   // stage 2: doubled sums and pitch clamp test
   logic     v2_ff;
   side_type side2_ff;
   side_type side2_in;

   always_comb begin
      side2_in.sr = (SW'(wx_ff) + SW'(yz_ff)) <<< 1;
      side2_in.cr = ONE - ((SW'(xx_ff) + SW'(yy_ff)) <<< 1);
      side2_in.sp = (SW'(wy_ff) - SW'(zx_ff)) <<< 1;
      side2_in.sy = (SW'(wz_ff) + SW'(xy_ff)) <<< 1;
      side2_in.cy = ONE - ((SW'(yy_ff) + SW'(zz_ff)) <<< 1);
      side2_in.clamped = (side2_in.sp >= ONE) || (side2_in.sp <= -ONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff    <= v1_ff;
         side2_ff <= side2_in;
      end
   end

   // stage 3: square of the pitch sine
   logic                 v3_ff;
   side_type             side3_ff;
   logic signed [RW-1:0] sp_narrow;
   logic signed [NW-1:0] sq_in;
   logic        [NW-1:0] sq_ff;

   assign sp_narrow = side2_ff.sp[RW-1:0];
   assign sq_in     = sp_narrow * sp_narrow;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff    <= v2_ff;
         side3_ff <= side2_ff;
         sq_ff    <= sq_in;
      end
   end

   logic [NW-1:0] rad;
   assign rad = (NW'(1) << 60) - sq_ff;

   logic          vs;
   logic [RW-1:0] root;
   side_type      side_s;

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_n      (rad),
      .in_side   (side3_ff),
      .out_valid (vs),
      .out_root  (root),
      .out_side  (side_s)
   );

   logic        v_roll, v_pitch, v_yaw;
   logic [31:0] a_roll, a_pitch, a_yaw;

   qte_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vs),
      .in_y      (CW'(side_s.sr)),
      .in_x      (CW'(side_s.cr)),
      .out_valid (v_roll),
      .out_angle (a_roll)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vs),
      .in_y      (CW'(side_s.sp)),
      .in_x      ({{(CW-RW){1'b0}}, root}),
      .out_valid (v_pitch),
      .out_angle (a_pitch)
   );

   qte_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vs),
      .in_y      (CW'(side_s.sy)),
      .in_x      (CW'(side_s.cy)),
      .out_valid (v_yaw),
      .out_angle (a_yaw)
   );

   // carry clamp flag and sign alongside the CORDIC stages
   logic cl_ff  [0:NST];
   logic pos_ff [0:NST];

   always_ff @(posedge clock) begin
      if (en) begin
         cl_ff[0]  <= side_s.clamped;
         pos_ff[0] <= side_s.sp > 0;
         for (int i = 1; i <= NST; i++) begin
            cl_ff[i]  <= cl_ff[i-1];
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   typedef struct packed {
      logic [AW-1:0] roll;
      logic [AW-1:0] pitch;
      logic [AW-1:0] yaw;
      logic          clamped;
   } word_type;

   logic     p_valid;
   word_type p_word;

   assign p_valid       = v_roll & v_pitch & v_yaw;
   assign p_word.roll   = to_angle(a_roll);
   assign p_word.yaw    = to_angle(a_yaw);
   assign p_word.clamped = cl_ff[NST];
   assign p_word.pitch  = cl_ff[NST] ? (pos_ff[NST] ? QUARTER_POS : QUARTER_NEG)
                                     : to_angle(a_pitch);

   // output register plus skid entry
   logic     out_valid_ff, skid_valid_ff;
   word_type out_ff, skid_ff;

   assign en   = !skid_valid_ff;
   assign take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (p_valid) begin
         if (!out_valid_ff || take) begin
            out_ff       <= p_word;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= p_word;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_roll_angle    = out_ff.roll;
   assign rsp_pitch_angle   = out_ff.pitch;
   assign rsp_yaw_angle     = out_ff.yaw;
   assign rsp_pitch_clamped = out_ff.clamped;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without output word");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> skid_valid_ff)
      else $error("skid entry dropped while output stalled");

   a_clamp_quarter: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle == QUARTER_POS || rsp_pitch_angle == QUARTER_NEG))
      else $error("clamped pitch is not a quarter turn");

   a_cordic_lockstep: assert property (@(posedge clock) disable iff (reset)
      (v_roll == v_pitch) && (v_roll == v_yaw))
      else $error("CORDIC lanes out of step");
endmodule
`default_nettype wire
